// ----- src/skte_pkg.sv -----
package skte_pkg;

	localparam int CapacityDef = 64;

	localparam logic [15:0] KeyMinRst   = 16'd42900;
	localparam logic [15:0] KeyMaxRst   = 16'd45150;
	localparam logic [9:0]  ValueMinRst = 10'd200;
	localparam logic [9:0]  ValueMaxRst = 10'd600;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_LIST   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_BAD_KEY   = 3'd2,
		ST_BAD_VALUE = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5,
		ST_NO_MATCH  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_KEY_MIN   = 2'd0,
		REG_KEY_MAX   = 2'd1,
		REG_VALUE_MIN = 2'd2,
		REG_VALUE_MAX = 2'd3
	} reg_t;

	// operations the controller asks of the datapath
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_RD     = 3'd1,
		OP_SHUP   = 3'd2,
		OP_SHDN   = 3'd3,
		OP_WRITE  = 3'd4,
		OP_WRVAL  = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] addr;
		logic [15:0] wkey;
		logic [9:0]  wval;
	} dp_cmd_t;

	typedef struct packed {
		logic [15:0] rkey;
		logic [9:0]  rval;
	} dp_stat_t;

endpackage

// ----- src/skte_datapath.sv -----
module skte_datapath #(
	parameter int CAPACITY = skte_pkg::CapacityDef,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic               clk,
	input  skte_pkg::dp_cmd_t  cmd,
	output skte_pkg::dp_stat_t stat
);

	logic [15:0] key_mem [CAPACITY];
	logic [9:0]  val_mem [CAPACITY];
	logic [15:0] rkey_q;
	logic [9:0]  rval_q;
	logic [AW-1:0] a;

	assign a = cmd.addr[AW-1:0];

	// one read or one write a cycle; a shift writes the word held from the most recent read
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			skte_pkg::OP_RD: begin
				rkey_q <= key_mem[a];
				rval_q <= val_mem[a];
			end
			skte_pkg::OP_SHUP, skte_pkg::OP_SHDN: begin
				key_mem[a] <= rkey_q;
				val_mem[a] <= rval_q;
			end
			skte_pkg::OP_WRITE: begin
				key_mem[a] <= cmd.wkey;
				val_mem[a] <= cmd.wval;
			end
			skte_pkg::OP_WRVAL: val_mem[a] <= cmd.wval;
			default: ;
		endcase
	end

	assign stat.rkey = rkey_q;
	assign stat.rval = rval_q;

endmodule

// ----- src/skte_ctrl.sv -----
module skte_ctrl #(
	parameter int CAPACITY = skte_pkg::CapacityDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,
	output logic               m_tlast,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output skte_pkg::dp_cmd_t  dcmd,
	input  skte_pkg::dp_stat_t dstat
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_BSRD  = 10'b0000000010,
		S_BSCMP = 10'b0000000100,
		S_DECIDE= 10'b0000001000,
		S_SHRD  = 10'b0000010000,
		S_SHWR  = 10'b0000100000,
		S_SCRD  = 10'b0001000000,
		S_SCCMP = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_SCOUT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [2:0]  cmd_q;
	logic [15:0] key_q;
	logic [9:0]  val_q;
	logic [6:0]  cnt_q, lo_q, hi_q, mid_q, i_q, idx_q;
	logic        hit_q, found_q;
	logic [15:0] kmin_q, kmax_q;
	logic [9:0]  vmin_q, vmax_q;
	logic        ov_q, olast_q;
	logic [2:0]  ost_q;
	logic [15:0] okey_q;
	logic [9:0]  oval_q;
	logic [5:0]  opos_q;
	logic        key_ok, val_ok;
	logic [6:0]  mid_n;

	assign key_ok = (key_q >= kmin_q) && (key_q <= kmax_q);
	assign val_ok = (val_q >= vmin_q) && (val_q <= vmax_q);
	assign mid_n  = 7'((8'(lo_q) + 8'(hi_q)) >> 1);

	assign s_tready  = (state_q == S_IDLE) && !ov_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = ov_q;
	assign m_tlast   = olast_q;
	assign m_tdata   = {6'd0, cnt_q, opos_q, oval_q, okey_q, ost_q};

	always_comb begin
		dcmd = '0;
		dcmd.op = skte_pkg::OP_NONE;
		dcmd.wkey = key_q;
		dcmd.wval = val_q;
		unique case (state_q)
			S_BSRD: begin
				dcmd.op = skte_pkg::OP_RD;
				dcmd.addr = mid_n;
			end
			S_SHRD: begin
				dcmd.op = skte_pkg::OP_RD;
				dcmd.addr = (cmd_q == skte_pkg::CMD_INSERT) ? 7'(i_q - 7'd1) : 7'(i_q + 7'd1);
			end
			S_SHWR: begin
				dcmd.op = skte_pkg::OP_SHUP;
				dcmd.addr = i_q;
			end
			S_SCRD: begin
				dcmd.op = skte_pkg::OP_RD;
				dcmd.addr = i_q;
			end
			default: ;
		endcase
		if (state_q == S_DECIDE && hit_q && val_ok &&
				(cmd_q == skte_pkg::CMD_INSERT || cmd_q == skte_pkg::CMD_UPDATE)) begin
			dcmd.op = skte_pkg::OP_WRVAL;
			dcmd.addr = idx_q;
		end
		if (state_q == S_SHRD && cmd_q == skte_pkg::CMD_INSERT && i_q == idx_q) begin
			dcmd.op = skte_pkg::OP_WRITE;
			dcmd.addr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
			kmin_q <= skte_pkg::KeyMinRst;
			kmax_q <= skte_pkg::KeyMaxRst;
			vmin_q <= skte_pkg::ValueMinRst;
			vmax_q <= skte_pkg::ValueMaxRst;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					skte_pkg::REG_KEY_MIN:   kmin_q <= cfg_data;
					skte_pkg::REG_KEY_MAX:   kmax_q <= cfg_data;
					skte_pkg::REG_VALUE_MIN: vmin_q <= cfg_data[9:0];
					default:                 vmax_q <= cfg_data[9:0];
				endcase
			end
			if (ov_q && m_tready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && !ov_q) begin
					cmd_q <= s_tdata[2:0];
					key_q <= s_tdata[18:3];
					val_q <= s_tdata[28:19];
					lo_q <= '0;
					hi_q <= cnt_q;
					hit_q <= 1'b0;
					i_q <= '0;
					found_q <= 1'b0;
					unique case (s_tdata[2:0])
						skte_pkg::CMD_INSERT, skte_pkg::CMD_REMOVE, skte_pkg::CMD_UPDATE:
							state_q <= S_BSCMP;
						skte_pkg::CMD_SEARCH, skte_pkg::CMD_LIST:
							state_q <= S_SCRD;
						default: state_q <= S_IDLE;
					endcase
				end
				S_BSCMP: begin
					if (!key_ok) begin
						state_q <= S_DECIDE;
					end else if (lo_q < hi_q) begin
						mid_q <= mid_n;
						state_q <= S_BSRD;
					end else begin
						idx_q <= lo_q;
						state_q <= S_DECIDE;
					end
				end
				S_BSRD: state_q <= S_SCCMP;
				S_SCCMP: begin
					if (cmd_q == skte_pkg::CMD_SEARCH || cmd_q == skte_pkg::CMD_LIST) begin
						if (cmd_q == skte_pkg::CMD_LIST || dstat.rval == val_q) begin
							if (found_q) begin
								// send the held hit, the new one is loaded once it is taken
								ov_q <= 1'b1;
								state_q <= S_SCOUT;
							end else begin
								ost_q <= skte_pkg::ST_OK;
								okey_q <= dstat.rkey;
								oval_q <= dstat.rval;
								opos_q <= i_q[5:0];
								olast_q <= 1'b0;
								found_q <= 1'b1;
								i_q <= 7'(i_q + 7'd1);
								state_q <= S_SCRD;
							end
						end else begin
							i_q <= 7'(i_q + 7'd1);
							state_q <= S_SCRD;
						end
					end else if (dstat.rkey == key_q) begin
						hit_q <= 1'b1;
						idx_q <= mid_q;
						state_q <= S_DECIDE;
					end else begin
						if (dstat.rkey > key_q) hi_q <= mid_q;
						else lo_q <= 7'(mid_q + 7'd1);
						state_q <= S_BSCMP;
					end
				end
				S_DECIDE: begin
					ost_q <= skte_pkg::ST_OK;
					okey_q <= key_q;
					oval_q <= val_q;
					opos_q <= idx_q[5:0];
					olast_q <= 1'b1;
					state_q <= S_OUT;
					if (!key_ok) begin
						ost_q <= skte_pkg::ST_BAD_KEY;
						opos_q <= '0;
					end else unique case (cmd_q)
						skte_pkg::CMD_INSERT: begin
							if (!val_ok) begin
								ost_q <= skte_pkg::ST_BAD_VALUE;
								opos_q <= '0;
							end else if (hit_q) begin
								ost_q <= skte_pkg::ST_REPLACED;
							end else if (cnt_q >= 7'(CAPACITY)) begin
								ost_q <= skte_pkg::ST_FULL;
								opos_q <= '0;
							end else begin
								i_q <= cnt_q;
								state_q <= S_SHRD;
							end
						end
						skte_pkg::CMD_REMOVE: begin
							if (!hit_q) begin
								ost_q <= skte_pkg::ST_NOT_FOUND;
								opos_q <= '0;
							end else begin
								oval_q <= dstat.rval;
								i_q <= idx_q;
								state_q <= S_SHRD;
							end
						end
						default: begin
							if (!hit_q) begin
								ost_q <= skte_pkg::ST_NOT_FOUND;
								opos_q <= '0;
							end else if (!val_ok) begin
								ost_q <= skte_pkg::ST_BAD_VALUE;
								opos_q <= '0;
							end
						end
					endcase
				end
				S_SHRD: begin
					if (cmd_q == skte_pkg::CMD_INSERT) begin
						if (i_q == idx_q) begin
							cnt_q <= 7'(cnt_q + 7'd1);
							state_q <= S_OUT;
						end else state_q <= S_SHWR;
					end else begin
						if (7'(i_q + 7'd1) >= cnt_q) begin
							cnt_q <= 7'(cnt_q - 7'd1);
							state_q <= S_OUT;
						end else state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					i_q <= (cmd_q == skte_pkg::CMD_INSERT) ? 7'(i_q - 7'd1) : 7'(i_q + 7'd1);
					state_q <= S_SHRD;
				end
				S_SCRD: begin
					if (cmd_q == skte_pkg::CMD_SEARCH && !val_ok) begin
						ost_q <= skte_pkg::ST_BAD_VALUE;
						okey_q <= key_q;
						oval_q <= val_q;
						opos_q <= '0;
						olast_q <= 1'b1;
						state_q <= S_OUT;
					end else if (i_q >= cnt_q) begin
						if (found_q) begin
							olast_q <= 1'b1;
							ov_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ost_q <= skte_pkg::ST_NO_MATCH;
							okey_q <= '0;
							oval_q <= (cmd_q == skte_pkg::CMD_SEARCH) ? val_q : 10'd0;
							opos_q <= '0;
							olast_q <= 1'b1;
							state_q <= S_OUT;
						end
					end else state_q <= S_SCCMP;
				end
				S_OUT: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCOUT: if (!ov_q) begin
					// hold the hit to learn whether a later one follows
					okey_q <= dstat.rkey;
					oval_q <= dstat.rval;
					opos_q <= i_q[5:0];
					i_q <= 7'(i_q + 7'd1);
					state_q <= S_SCRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/sorted_key_table_engine_top.sv -----
// insert and remove run a binary search over the sorted table, then shift the entries
// past the position one slot at a time; search and list read and compare every entry
// in turn, plus the wait for each output handshake
// throughput is one command at a time; the next command is taken after the last
// result transaction, bounded by the shift and scan loops over the table memory
// reset: arst_n clears the entry count and loads the default bounds
module sorted_key_table_engine_top #(
	parameter int CAPACITY = skte_pkg::CapacityDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // command, key, value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status, out_key, out_value, position, entry_count
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	skte_pkg::dp_cmd_t  dcmd;
	skte_pkg::dp_stat_t dstat;

	skte_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.dcmd, .dstat
	);

	skte_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .cmd(dcmd), .stat(dstat)
	);

endmodule
